@@ hw/rtl/brj_pkg.sv @@
package brj_pkg;

	localparam int POS_W = 32;
	localparam int ANG_W = 16;
	localparam int SLOT_W = 10;
	localparam int PC_W = 11;
	localparam int PCOL_W = 12;
	localparam int LCOL_W = 13;
	localparam int Z_W = 30;
	localparam int V_W = 36;
	localparam int DEN_W = 67;
	localparam int NUM_W = 100;
	localparam int Q_STEPS = 33;

	localparam logic signed [Z_W-1:0] PI_Z24 = 30'sd52707179;
	localparam logic signed [ANG_W+1:0] PI_Q13 = 18'sd25736;
	localparam logic signed [ANG_W+1:0] TWO_PI_Q13 = 18'sd51472;

	typedef struct packed {
		logic signed [POS_W-1:0] robot_x;
		logic signed [POS_W-1:0] robot_y;
		logic signed [ANG_W-1:0] robot_heading;
		logic signed [POS_W-1:0] landmark_x;
		logic signed [POS_W-1:0] landmark_y;
		logic signed [ANG_W-1:0] measured_bearing;
		logic [SLOT_W-1:0] pose_slot;
		logic [SLOT_W-1:0] landmark_slot;
	} brj_in_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] bearing_error;
		logic signed [POS_W-1:0] jac_robot_x;
		logic signed [POS_W-1:0] jac_robot_y;
		logic signed [POS_W-1:0] jac_robot_heading;
		logic signed [POS_W-1:0] jac_landmark_x;
		logic signed [POS_W-1:0] jac_landmark_y;
		logic [PCOL_W-1:0] pose_column;
		logic [LCOL_W-1:0] landmark_column;
		logic degenerate;
	} brj_out_t;

	function automatic logic signed [Z_W-1:0] atan_z24(input int i);
		logic signed [Z_W-1:0] r;
		unique case (i)
			0: r = 30'sd13176795;
			1: r = 30'sd7778716;
			2: r = 30'sd4110060;
			3: r = 30'sd2086331;
			4: r = 30'sd1047214;
			5: r = 30'sd524117;
			6: r = 30'sd262123;
			7: r = 30'sd131069;
			default: r = (i < 25) ? Z_W'(30'sd1 <<< (24 - i)) : '0;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/bearing_residual_jacobian.sv @@
// From the accepting edge to done: three front stages, then the registered divider steps.
// Throughput: one word per cycle; busy stays low.
// The CORDIC path has NS registered stages (CORDIC_STAGES, capped at 32) and is padded to meet the divider.
// Reset clears pose_count and all valid bits; payload registers are not reset.
// The receiver cannot stall: done is high for exactly one cycle per word.
module bearing_residual_jacobian import brj_pkg::*; #(
	parameter int MAX_POSES = 1024,
	parameter int MAX_LANDMARKS = 1024,
	parameter int CORDIC_STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  brj_in_t in_word,
	output logic done,
	output brj_out_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [PC_W-1:0] cfg_data
);
	localparam int NS = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
	localparam int DIV_LAT = Q_STEPS + 1;
	localparam int LAT = DIV_LAT + 3;

	logic [PC_W-1:0] pose_count_q;
	assign cfg_ready = 1'b1;
	assign busy = 1'b0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			pose_count_q <= cfg_data;
		end
	end

	logic accept;
	assign accept = start && !busy;

	// stage 1: differences and columns
	logic v_s1;
	logic signed [POS_W:0] dx_s1, dy_s1;
	logic signed [POS_W-1:0] lx_s1, ly_s1;
	logic signed [ANG_W-1:0] hd_s1, mb_s1;
	logic [PCOL_W-1:0] pcol_s1;
	logic [LCOL_W-1:0] lcol_s1;
	logic [SLOT_W-1:0] ps, ls;
	logic [PC_W-1:0] pc;

	always_comb begin
		ps = (32'(in_word.pose_slot) > MAX_POSES - 1) ? SLOT_W'(MAX_POSES - 1)
			: in_word.pose_slot;
		ls = (32'(in_word.landmark_slot) > MAX_LANDMARKS - 1)
			? SLOT_W'(MAX_LANDMARKS - 1) : in_word.landmark_slot;
		pc = (32'(pose_count_q) > MAX_POSES) ? PC_W'(MAX_POSES) : pose_count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= 33'(in_word.landmark_x) - 33'(in_word.robot_x);
		dy_s1 <= 33'(in_word.landmark_y) - 33'(in_word.robot_y);
		lx_s1 <= in_word.landmark_x;
		ly_s1 <= in_word.landmark_y;
		hd_s1 <= in_word.robot_heading;
		mb_s1 <= in_word.measured_bearing;
		pcol_s1 <= PCOL_W'(14'(ps) * 14'd3);
		lcol_s1 <= LCOL_W'(14'(pc) * 14'd3 + 14'(ls) * 14'd2);
	end

	// stage 2: squares and dot-product terms
	logic v_s2;
	logic [DEN_W-1:0] dxx_s2, dyy_s2;
	logic signed [NUM_W-1:0] tx_s2, ty_s2;
	logic signed [POS_W:0] dx_s2, dy_s2;
	logic signed [2*POS_W+1:0] dxx_w, dyy_w;
	logic signed [2*POS_W:0] tx_w, ty_w;

	assign dxx_w = dx_s1 * dx_s1;
	assign dyy_w = dy_s1 * dy_s1;
	assign tx_w = dx_s1 * lx_s1;
	assign ty_w = dy_s1 * ly_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		dxx_s2 <= DEN_W'($unsigned(dxx_w));
		dyy_s2 <= DEN_W'($unsigned(dyy_w));
		tx_s2 <= NUM_W'(tx_w);
		ty_s2 <= NUM_W'(ty_w);
		dx_s2 <= dx_s1;
		dy_s2 <= dy_s1;
	end

	// stage 3: denominator and heading numerator
	logic v_s3;
	logic [DEN_W-1:0] den_s3;
	logic signed [NUM_W-1:0] th_s3;
	logic signed [POS_W:0] dx_s3, dy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		den_s3 <= dxx_s2 + dyy_s2;
		th_s3 <= -(tx_s2 + ty_s2);
		dx_s3 <= dx_s2;
		dy_s3 <= dy_s2;
	end

	// dividers: round(num*2^sh/den) via (2|num|<<sh + den) / 2den
	logic [4:0] dv;
	logic signed [POS_W-1:0] jq [5];
	logic [NUM_W-1:0] n2 [5];
	logic nneg [5];
	logic [DEN_W:0] d2;
	logic [NUM_W-1:0] mdx, mdy, mth;

	always_comb begin
		d2 = {den_s3, 1'b0};
		mdx = NUM_W'($unsigned(dx_s3[POS_W] ? -dx_s3 : dx_s3));
		mdy = NUM_W'($unsigned(dy_s3[POS_W] ? -dy_s3 : dy_s3));
		mth = th_s3[NUM_W-1] ? NUM_W'(-th_s3) : NUM_W'(th_s3);
		n2[0] = (mdy << 33) + NUM_W'(den_s3);
		nneg[0] = dy_s3[POS_W];
		n2[1] = (mdx << 33) + NUM_W'(den_s3);
		nneg[1] = !dx_s3[POS_W] && (dx_s3 != '0);
		n2[2] = (mth << 17) + NUM_W'(den_s3);
		nneg[2] = th_s3[NUM_W-1];
		n2[3] = n2[0];
		nneg[3] = !dy_s3[POS_W] && (dy_s3 != '0);
		n2[4] = n2[1];
		nneg[4] = dx_s3[POS_W];
	end

	for (genvar k = 0; k < 5; k++) begin : g_div
		brj_div u_div (
			.clk(clk), .arst_n(arst_n), .in_valid(v_s3), .neg(nneg[k]),
			.n2(n2[k]), .d2(d2), .out_valid(dv[k]), .quot(jq[k])
		);
	end

	// CORDIC path
	logic signed [V_W-1:0] cx [NS+1];
	logic signed [V_W-1:0] cy [NS+1];
	logic signed [Z_W-1:0] cz [NS+1];
	logic signed [ANG_W-1:0] chd [NS+1];
	logic signed [ANG_W-1:0] cmb [NS+1];
	logic [NS:0] cv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv[0] <= 1'b0;
		end else begin
			cv[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (dx_s1[POS_W]) begin
			cx[0] <= -V_W'(dx_s1);
			cy[0] <= -V_W'(dy_s1);
			cz[0] <= dy_s1[POS_W] ? -PI_Z24 : PI_Z24;
		end else begin
			cx[0] <= V_W'(dx_s1);
			cy[0] <= V_W'(dy_s1);
			cz[0] <= '0;
		end
		chd[0] <= hd_s1;
		cmb[0] <= mb_s1;
	end

	for (genvar i = 0; i < NS; i++) begin : g_cordic
		logic signed [V_W-1:0] xs, ys;
		assign xs = cx[i] >>> i;
		assign ys = cy[i] >>> i;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv[i+1] <= 1'b0;
			end else begin
				cv[i+1] <= cv[i];
			end
		end
		always_ff @(posedge clk) begin
			if (cy[i] > 0) begin
				cx[i+1] <= cx[i] + ys;
				cy[i+1] <= cy[i] - xs;
				cz[i+1] <= cz[i] + atan_z24(i);
			end else begin
				cx[i+1] <= cx[i] - ys;
				cy[i+1] <= cy[i] + xs;
				cz[i+1] <= cz[i] - atan_z24(i);
			end
			chd[i+1] <= chd[i];
			cmb[i+1] <= cmb[i];
		end
	end

	// side fields, aligned to divider output
	localparam int SD = LAT - 1;
	logic [PCOL_W-1:0] pq [SD];
	logic [LCOL_W-1:0] lq [SD];
	logic gq [SD];
	always_ff @(posedge clk) begin
		pq[0] <= pcol_s1;
		lq[0] <= lcol_s1;
		gq[0] <= (dx_s1 == '0) && (dy_s1 == '0);
	end
	for (genvar j = 1; j < SD; j++) begin : g_sd
		always_ff @(posedge clk) begin
			pq[j] <= pq[j-1];
			lq[j] <= lq[j-1];
			gq[j] <= gq[j-1];
		end
	end

	// residual; drop the direction when the landmark sits on the robot
	logic signed [Z_W+1:0] esum;
	logic signed [ANG_W+1:0] e0, e1;
	logic signed [ANG_W-1:0] err_s4;

	always_comb begin
		esum = (gq[NS] ? 32'sd0 : 32'(cz[NS])) - (32'(chd[NS]) <<< 11)
			- (32'(cmb[NS]) <<< 11) + 32'sd1024;
		e0 = 18'(esum >>> 11);
		if (e0 >= PI_Q13) begin
			e1 = e0 - TWO_PI_Q13;
		end else if (e0 < -PI_Q13) begin
			e1 = e0 + TWO_PI_Q13;
		end else begin
			e1 = e0;
		end
		if (e1 >= PI_Q13) begin
			e1 = e1 - TWO_PI_Q13;
		end else if (e1 < -PI_Q13) begin
			e1 = e1 + TWO_PI_Q13;
		end
	end

	always_ff @(posedge clk) begin
		err_s4 <= ANG_W'(e1);
	end

	localparam int ED = LAT - NS - 4;
	logic signed [ANG_W-1:0] eq [ED+1];
	always_ff @(posedge clk) begin
		eq[0] <= err_s4;
	end
	for (genvar j = 0; j < ED; j++) begin : g_ed
		always_ff @(posedge clk) begin
			eq[j+1] <= eq[j];
		end
	end

	logic degen;
	assign degen = gq[SD-1];
	assign done = dv[0];
	always_comb begin
		result.bearing_error = (ED >= 0) ? eq[ED] : err_s4;
		result.jac_robot_x = degen ? 32'sh7FFFFFFF : jq[0];
		result.jac_robot_y = degen ? 32'sh7FFFFFFF : jq[1];
		result.jac_robot_heading = degen ? 32'sh7FFFFFFF : jq[2];
		result.jac_landmark_x = degen ? 32'sh7FFFFFFF : jq[3];
		result.jac_landmark_y = degen ? 32'sh7FFFFFFF : jq[4];
		result.pose_column = pq[SD-1];
		result.landmark_column = lq[SD-1];
		result.degenerate = degen;
	end

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> ##(DIV_LAT) done) else $error("divider latency slip");
	a_cordic: assert property (@(posedge clk) disable iff (!arst_n)
		cv[NS] |-> ##(LAT - NS - 2) done) else $error("cordic path out of step");
	a_sync: assert property (@(posedge clk) disable iff (!arst_n)
		dv == 5'b0 || dv == 5'b11111) else $error("divider lanes out of step");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg_valid && cfg_ready) |=> $stable(pose_count_q)) else $error("pose count drift");
endmodule

@@ hw/rtl/brj_div.sv @@
module brj_div import brj_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic neg,
	input  logic [NUM_W-1:0] n2,
	input  logic [DEN_W:0] d2,
	output logic out_valid,
	output logic signed [POS_W-1:0] quot
);
	logic [Q_STEPS:0] v_q;
	logic [NUM_W-1:0] rem_q [Q_STEPS+1];
	logic [DEN_W:0] den_q [Q_STEPS+1];
	logic [Q_STEPS-1:0] m_q [Q_STEPS+1];
	logic neg_q [Q_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[Q_STEPS-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		rem_q[0] <= n2;
		den_q[0] <= d2;
		m_q[0] <= '0;
		neg_q[0] <= neg;
	end

	for (genvar s = 0; s < Q_STEPS; s++) begin : g_step
		localparam int B = Q_STEPS - 1 - s;
		logic [NUM_W:0] t;
		logic ge;
		assign t = {{(NUM_W-DEN_W){1'b0}}, den_q[s]} << B;
		assign ge = {1'b0, rem_q[s]} >= t;
		always_ff @(posedge clk) begin
			rem_q[s+1] <= ge ? NUM_W'({1'b0, rem_q[s]} - t) : rem_q[s];
			den_q[s+1] <= den_q[s];
			m_q[s+1] <= m_q[s] | (Q_STEPS'(ge) << B);
			neg_q[s+1] <= neg_q[s];
		end
	end

	logic [Q_STEPS-1:0] m;
	assign m = m_q[Q_STEPS];
	assign out_valid = v_q[Q_STEPS];
	always_comb begin
		if (neg_q[Q_STEPS]) begin
			quot = (m >= Q_STEPS'(33'h80000000)) ? 32'sh80000000 : POS_W'(-m);
		end else begin
			quot = (m > Q_STEPS'(33'h7FFFFFFF)) ? 32'sh7FFFFFFF : POS_W'(m);
		end
	end
endmodule

@@ dv/brj_checker.sv @@
`timescale 1ns / 1ps
module brj_checker import brj_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  brj_in_t in_word,
	input  logic done,
	input  brj_out_t result,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [PC_W-1:0] cfg_data,
	output int pending,
	output int errors
);

	localparam int MAX_POSES = 1024;
	localparam int MAX_LANDMARKS = 1024;
	localparam int STAGES = 16;
	localparam longint DIR_PI = 52707179;
	localparam longint ERR_PI = 25736;
	localparam longint ERR_TWO_PI = 51472;

	localparam longint ARCTAN_Z24 [16] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512
	};

	logic [PC_W-1:0] pose_count_q;
	brj_out_t expected_words[$];

	function automatic longint cordic_direction(input longint x0, input longint y0);
		longint x, y, z, xs, ys;
		x = x0;
		y = y0;
		z = 0;
		if (x < 0) begin
			z = (y >= 0) ? DIR_PI : -DIR_PI;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys;
				y -= xs;
				z += ARCTAN_Z24[i];
			end else begin
				x -= ys;
				y += xs;
				z -= ARCTAN_Z24[i];
			end
		end
		return z;
	endfunction

	// round half away from zero, saturate to 32 bits
	function automatic logic [31:0] round_quot(input logic signed [191:0] num, input int sh,
			input logic [191:0] den);
		logic neg;
		logic [191:0] mag, q;
		neg = num[191];
		mag = neg ? 192'(-num) : 192'(num);
		q = (((mag << sh) << 1) + den) / (den << 1);
		if (neg)
			return (q >= 192'h8000_0000) ? 32'h8000_0000 : 32'(-q[31:0]);
		return (q > 192'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
	endfunction

	function automatic brj_out_t predict_residual(input brj_in_t w, input logic [PC_W-1:0] pc_in);
		brj_out_t r;
		longint dx, dy, z, e, ps, ls, pc;
		logic signed [191:0] sdx, sdy, th, den;
		dx = longint'(w.landmark_x) - longint'(w.robot_x);
		dy = longint'(w.landmark_y) - longint'(w.robot_y);
		r.degenerate = (dx == 0 && dy == 0);
		z = r.degenerate ? 0 : cordic_direction(dx, dy);
		e = (z - longint'(w.robot_heading) * 2048 - longint'(w.measured_bearing) * 2048
			+ 1024) >>> 11;
		while (e >= ERR_PI)
			e -= ERR_TWO_PI;
		while (e < -ERR_PI)
			e += ERR_TWO_PI;
		r.bearing_error = e[ANG_W-1:0];
		if (r.degenerate) begin
			r.jac_robot_x = 32'h7FFF_FFFF;
			r.jac_robot_y = 32'h7FFF_FFFF;
			r.jac_robot_heading = 32'h7FFF_FFFF;
			r.jac_landmark_x = 32'h7FFF_FFFF;
			r.jac_landmark_y = 32'h7FFF_FFFF;
		end else begin
			sdx = 192'(dx);
			sdy = 192'(dy);
			th = sdx * 192'(w.landmark_x) + sdy * 192'(w.landmark_y);
			den = sdx * sdx + sdy * sdy;
			r.jac_robot_x = round_quot(sdy, 32, den);
			r.jac_robot_y = round_quot(-sdx, 32, den);
			r.jac_robot_heading = round_quot(-th, 16, den);
			r.jac_landmark_x = round_quot(-sdy, 32, den);
			r.jac_landmark_y = round_quot(sdx, 32, den);
		end
		pc = (pc_in > MAX_POSES) ? MAX_POSES : pc_in;
		ps = (w.pose_slot > MAX_POSES - 1) ? MAX_POSES - 1 : w.pose_slot;
		ls = (w.landmark_slot > MAX_LANDMARKS - 1) ? MAX_LANDMARKS - 1 : w.landmark_slot;
		r.pose_column = PCOL_W'(3 * ps);
		r.landmark_column = LCOL_W'(3 * pc + 2 * ls);
		return r;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
	end

	assign pending = expected_words.size();

	always @(posedge clk or negedge arst_n) begin
		brj_out_t want;
		if (!arst_n) begin
			pose_count_q <= '0;
			expected_words.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				pose_count_q <= cfg_data;
			if (start && !busy)
				expected_words.insert(expected_words.size(),
					predict_residual(in_word, pose_count_q));
			if (done) begin
				if (expected_words.size() == 0) begin
					report("unexpected word", longint'(result.bearing_error), 0);
				end else begin
					want = expected_words.pop_front();
					if (result.bearing_error !== want.bearing_error)
						report("bearing_error", result.bearing_error, want.bearing_error);
					if (result.jac_robot_x !== want.jac_robot_x)
						report("jac_robot_x", result.jac_robot_x, want.jac_robot_x);
					if (result.jac_robot_y !== want.jac_robot_y)
						report("jac_robot_y", result.jac_robot_y, want.jac_robot_y);
					if (result.jac_robot_heading !== want.jac_robot_heading)
						report("jac_robot_heading", result.jac_robot_heading,
							want.jac_robot_heading);
					if (result.jac_landmark_x !== want.jac_landmark_x)
						report("jac_landmark_x", result.jac_landmark_x, want.jac_landmark_x);
					if (result.jac_landmark_y !== want.jac_landmark_y)
						report("jac_landmark_y", result.jac_landmark_y, want.jac_landmark_y);
					if (result.pose_column !== want.pose_column)
						report("pose_column", result.pose_column, want.pose_column);
					if (result.landmark_column !== want.landmark_column)
						report("landmark_column", result.landmark_column, want.landmark_column);
					if (result.degenerate !== want.degenerate)
						report("degenerate", result.degenerate, want.degenerate);
				end
			end
		end
	end

endmodule

@@ dv/bearing_residual_jacobian_tb.sv @@
`timescale 1ns / 1ps
module bearing_residual_jacobian_tb;
	import brj_pkg::*;

	localparam int DRAIN_CYCLES = 70;
	localparam int IN_BITS = $bits(brj_in_t);

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	brj_in_t in_word;
	logic done;
	brj_out_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [PC_W-1:0] cfg_data;
	int pending;
	int errors;

	bearing_residual_jacobian u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.in_word(in_word),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	brj_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.in_word(in_word),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.pending(pending),
		.errors(errors)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	task automatic idle_gap();
		int n;
		n = $urandom_range(0, 9);
		if (n < 5)
			n = 0;
		else if (n < 9)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(4, 40);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_word(input brj_in_t w);
		start <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		idle_gap();
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_pose_count(input logic [PC_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic brj_in_t random_word();
		brj_in_t w;
		int mode;
		w = IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		mode = $urandom_range(0, 9);
		if (mode < 3) begin
			w.landmark_x = w.robot_x + $signed(32'($urandom_range(0, 2000)) - 32'd1000);
			w.landmark_y = w.robot_y + $signed(32'($urandom_range(0, 2000)) - 32'd1000);
		end else if (mode == 3) begin
			w.landmark_x = w.robot_x;
			w.landmark_y = w.robot_y + ($urandom_range(0, 1) ? 32'sd0 : $signed($urandom));
		end else if (mode == 4) begin
			w.landmark_x = w.robot_x + $signed(32'($urandom_range(0, 1 << 20)) - 32'(1 << 19));
			w.landmark_y = w.robot_y + $signed(32'($urandom_range(0, 1 << 20)) - 32'(1 << 19));
		end
		if ($urandom_range(0, 3) != 0) begin
			w.robot_heading = $signed(16'($urandom_range(0, 51471)) - 16'd25736);
			w.measured_bearing = $signed(16'($urandom_range(0, 51471)) - 16'd25736);
		end
		return w;
	endfunction

	function automatic brj_in_t make_word(input logic [31:0] rx, input logic [31:0] ry,
			input logic [15:0] hd, input logic [31:0] lx, input logic [31:0] ly,
			input logic [15:0] mb, input logic [9:0] ps, input logic [9:0] ls);
		brj_in_t w;
		w.robot_x = rx;
		w.robot_y = ry;
		w.robot_heading = hd;
		w.landmark_x = lx;
		w.landmark_y = ly;
		w.measured_bearing = mb;
		w.pose_slot = ps;
		w.landmark_slot = ls;
		return w;
	endfunction

	initial begin
		logic [PC_W-1:0] settings [5];
		arst_n = 1'b0;
		start = 1'b0;
		in_word = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		settings = '{11'd0, 11'd1024, 11'd2047, 11'd1025, 11'd0};
		settings[4] = 11'($urandom_range(1, 1023));
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(make_word(0, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_word(32'h8000_0000, 32'h8000_0000, 16'h8000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 16'h7FFF, 10'h3FF, 10'h3FF));
		send_word(make_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 32'h8000_0000,
			32'h8000_0000, 16'h8000, 10'h3FF, 0));
		send_word(make_word(0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 25735, 0, 10'h3FF));
		send_word(make_word(0, 0, 0, 32'hFFFF_0000, 0, -25736, 5, 7));
		send_word(make_word(0, 0, 0, 32'hFFFF_0000, 32'hFFFF_FFFF, 25735, 5, 7));
		send_word(make_word(0, 0, 0, 0, 1, 0, 1, 1));
		send_word(make_word(0, 0, 0, 0, -1, 0, 1, 1));
		send_word(make_word(0, 0, 0, 1, 0, 0, 2, 2));
		send_word(make_word(0, 0, 0, 1, 1, 0, 2, 2));
		send_word(make_word(32'h1234_5678, 32'h0001_0000, 16'sd25735, 32'h1234_5678,
			32'h0001_0000, -16'sd25736, 9, 9));
		send_word(make_word(32'h0001_0000, 0, -25736, 32'h0002_0000, 32'h0001_0000,
			25735, 100, 200));
		send_word(make_word(0, 0, 16'h7FFF, 32'h0010_0000, 32'h0010_0000, 16'h8000, 3, 4));
		send_word(make_word(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 512, 511));
		send_word(make_word(0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 0));
		drain();

		foreach (settings[i]) begin
			write_pose_count(settings[i]);
			send_word(make_word(0, 0, 0, 32'h0001_0000, 0, 0, 10'h3FF, 10'h3FF));
			repeat (340) send_word(random_word());
			drain();
		end
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
